FILE: hw/rtl/tecl_pkg.sv
package tecl_pkg;

    typedef logic [6:0] ch_t;
    typedef logic [7:0] col_t;

    typedef enum logic [1:0] {
        END_NONE  = 2'd0,
        END_CR    = 2'd1,
        END_TERM  = 2'd2,
        END_TRUNC = 2'd3
    } reason_t;

    // configuration register indexes
    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_TAB_WIDTH  = 1'b0;
    localparam reg_idx_t REG_LINE_WIDTH = 1'b1;

    localparam logic [6:0] TAB_WIDTH_RESET  = 7'd8;
    localparam logic [7:0] LINE_WIDTH_RESET = 8'd79;

    // character codes
    localparam ch_t CH_NUL    = 7'd0;
    localparam ch_t CH_TAB    = 7'd9;
    localparam ch_t CH_CR     = 7'd13;
    localparam ch_t CH_SPACE  = 7'd32;
    localparam ch_t CH_CARET  = 7'd94;
    localparam ch_t CTRL_BIAS = 7'd64;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic eval;
        logic push;
    } tecl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_tab;
        logic ended;
        logic div_last;
        logic last;
        logic can_push;
    } tecl_status_t;

endpackage

FILE: hw/rtl/tecl_item_if.sv
interface tecl_item_if import tecl_pkg::*; ();
    logic valid;
    logic ready;
    ch_t  ch;
    logic new_line;
    col_t start_offset;

    modport source (output valid, output ch, output new_line, output start_offset,
                    input ready);
    modport sink (input valid, input ch, input new_line, input start_offset,
                  output ready);
endinterface

FILE: hw/rtl/tecl_result_if.sv
interface tecl_result_if import tecl_pkg::*; ();
    logic    valid;
    logic    ready;
    ch_t     out_char;
    col_t    out_col;
    reason_t end_reason;
    logic    last;

    modport source (output valid, output out_char, output out_col, output end_reason,
                    output last, input ready);
    modport sink (input valid, input out_char, input out_col, input end_reason,
                  input last, output ready);
endinterface

FILE: hw/rtl/tecl_cfg_if.sv
interface tecl_cfg_if import tecl_pkg::*; ();
    logic       valid;
    logic       ready;
    reg_idx_t   index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/tecl_ctrl.sv
module tecl_ctrl import tecl_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  tecl_status_t st,
    output tecl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_EVAL = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   emit_done;

    // last result of the current word leaves this cycle
    assign emit_done  = (state_reg == S_EMIT) && st.can_push && st.last;
    assign item_ready = (state_reg == S_IDLE) || emit_done;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.load     = item_valid && item_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = st.in_tab ? S_MOD : S_EVAL;
                end
            end
            S_MOD:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = st.ended ? S_IDLE : S_EMIT;
            end
            S_EMIT:
            begin
                cmd.push = 1'b1;
                if (emit_done)
                begin
                    if (item_valid)
                    begin
                        state_next = st.in_tab ? S_MOD : S_EVAL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/tecl_datapath.sv
module tecl_datapath import tecl_pkg::*; #(
    parameter int TAB_LIMIT = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  tecl_cmd_t    cmd,
    output tecl_status_t st,
    input  ch_t          ch,
    input  logic         new_line,
    input  col_t         start_offset,
    input  logic         cfg_valid,
    input  reg_idx_t     cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         result_ready,
    output logic         result_valid,
    output ch_t          out_char,
    output col_t         out_col,
    output reason_t      end_reason,
    output logic         last
);

    logic [6:0] tab_width_reg;
    logic [7:0] line_width_reg;
    col_t       column_reg;
    col_t       offset_reg;
    logic       ended_reg;
    ch_t        ch_reg;
    logic [6:0] rem_reg;
    logic [2:0] bit_reg;
    col_t       start_reg;
    logic [6:0] cnt_reg;
    logic [6:0] idx_reg;
    reason_t    reason_reg;

    logic       out_valid_reg;
    ch_t        out_char_reg;
    col_t       out_col_reg;
    reason_t    out_reason_reg;
    logic       out_last_reg;

    logic [6:0] tab_min;
    logic [6:0] eff_tab;
    logic       is_tab;
    logic       is_ctrl;
    logic       is_nul;
    logic       is_cr;
    logic [7:0] shifted;
    logic [6:0] rem_step;
    logic [6:0] len;
    logic [9:0] span;
    logic       trunc;
    logic       can_push;
    logic       do_push;
    logic       last_item;
    ch_t        char_next;

    // effective tab width: zero reads as one, saturated at the limit
    assign tab_min = (tab_width_reg == 7'd0) ? 7'd1 : tab_width_reg;
    assign eff_tab = ({1'b0, tab_min} > 8'(TAB_LIMIT)) ? 7'(TAB_LIMIT) : tab_min;

    // character classes
    assign is_tab  = (ch_reg == CH_TAB);
    assign is_ctrl = (ch_reg[6:5] == 2'b00);
    assign is_nul  = (ch_reg == CH_NUL);
    assign is_cr   = (ch_reg == CH_CR);

    // one restoring step of column mod tab width, msb first
    assign shifted  = {rem_reg, column_reg[bit_reg]};
    assign rem_step = (shifted >= {1'b0, eff_tab}) ? 7'(shifted - {1'b0, eff_tab})
                                                   : shifted[6:0];

    // printed length and width check
    assign len   = is_tab ? (eff_tab - rem_reg) : (is_ctrl ? 7'd2 : 7'd1);
    assign span  = 10'(column_reg) + 10'(len) + 10'(offset_reg);
    assign trunc = span > 10'(line_width_reg);

    // output register handshake
    assign can_push  = !out_valid_reg || result_ready;
    assign do_push   = cmd.push && can_push;
    assign last_item = ({1'b0, idx_reg} + 8'd1) == {1'b0, cnt_reg};

    // character of the current result
    always_comb
    begin
        if (reason_reg != END_NONE)
        begin
            char_next = CH_NUL;
        end
        else if (is_tab)
        begin
            char_next = CH_SPACE;
        end
        else if (is_ctrl)
        begin
            char_next = (idx_reg == 7'd0) ? CH_CARET : (ch_reg | CTRL_BIAS);
        end
        else
        begin
            char_next = ch_reg;
        end
    end

    assign st.in_tab   = (ch == CH_TAB);
    assign st.ended    = ended_reg;
    assign st.div_last = (bit_reg == 3'd0);
    assign st.last     = last_item;
    assign st.can_push = can_push;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg  <= TAB_WIDTH_RESET;
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_TAB_WIDTH)
            begin
                tab_width_reg <= cfg_data[6:0];
            end
            else
            begin
                line_width_reg <= cfg_data;
            end
        end
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            offset_reg <= '0;
            ended_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (new_line)
            begin
                column_reg <= '0;
                offset_reg <= start_offset;
                ended_reg  <= 1'b0;
            end
        end
        else if (cmd.eval && !ended_reg)
        begin
            if (is_nul || is_cr || trunc)
            begin
                ended_reg <= 1'b1;
            end
            else
            begin
                column_reg <= column_reg + 8'(len);
            end
        end
    end

    // item, remainder and result sequencing
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg  <= ch;
            rem_reg <= '0;
            bit_reg <= 3'd7;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            bit_reg <= bit_reg - 3'd1;
        end
        if (cmd.eval)
        begin
            idx_reg   <= '0;
            start_reg <= column_reg;
            if (is_nul)
            begin
                reason_reg <= END_TERM;
                cnt_reg    <= 7'd1;
            end
            else if (is_cr)
            begin
                reason_reg <= END_CR;
                cnt_reg    <= 7'd1;
            end
            else if (trunc)
            begin
                reason_reg <= END_TRUNC;
                cnt_reg    <= 7'd1;
            end
            else
            begin
                reason_reg <= END_NONE;
                cnt_reg    <= len;
            end
        end
        if (do_push)
        begin
            idx_reg        <= idx_reg + 7'd1;
            out_char_reg   <= char_next;
            out_col_reg    <= start_reg;
            out_reason_reg <= reason_reg;
            out_last_reg   <= last_item;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_char     = out_char_reg;
    assign out_col      = out_col_reg;
    assign end_reason   = out_reason_reg;
    assign last         = out_last_reg;

endmodule

FILE: hw/rtl/tab_expand_caret_line_formatter_core.sv
// Line formatter: takes one 7-bit character per input word and gives the words to print,
// expanding tabs to spaces up to the next tab stop, showing control characters as a caret
// and the character plus 64, and closing the line with one ending word on carriage return,
// on a zero terminator or when the text would run past line_width. After an ending word,
// characters are dropped until a word with new_line set. Every tab first passes through a
// bit-serial remainder unit that finds the column modulo the tab width one bit per cycle,
// also a tab that is then dropped. Other characters go straight to evaluation. One result
// word leaves per cycle from the output register; a stalled output holds the emit sequence.
// Configuration writes are taken in any cycle and must be made while the block is idle.
module tab_expand_caret_line_formatter_core import tecl_pkg::*; #(
    parameter int TAB_LIMIT = 64
) (
    input  logic clk,
    input  logic rst_n,
    tecl_item_if.sink     item,
    tecl_result_if.source result,
    tecl_cfg_if.sink      cfg
);

    tecl_cmd_t    cmd;
    tecl_status_t st;

    assign cfg.ready = 1'b1;

    // sequencer
    tecl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .st         (st),
        .cmd        (cmd)
    );

    // line state, remainder unit and output register
    tecl_datapath #(
        .TAB_LIMIT (TAB_LIMIT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .ch           (item.ch),
        .new_line     (item.new_line),
        .start_offset (item.start_offset),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .out_char     (result.out_char),
        .out_col      (result.out_col),
        .end_reason   (result.end_reason),
        .last         (result.last)
    );

    // an accepted tab always goes through the remainder unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.ch == CH_TAB) |=> cmd.div_step)
        else $error("tab accepted without remainder pass");

    // the last remainder step hands over to evaluation
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && st.div_last) |=> cmd.eval)
        else $error("remainder finished without evaluation");

    // a character on an ended line gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && st.ended) |=> !cmd.push)
        else $error("result emitted for a dropped character");

endmodule

FILE: dv/tecl_print_checker.sv
`timescale 1ns / 1ps

module tecl_print_checker import tecl_pkg::*; #(
    parameter int TAB_LIMIT = 64
) (
    input  logic clk,
    input  logic rst_n,
    tecl_item_if   item,
    tecl_result_if result,
    tecl_cfg_if    cfg,
    output int     fail_count,
    output int     pending
);

    typedef struct packed {
        ch_t     ch;
        col_t    col;
        reason_t reason;
        logic    last;
    } print_word_t;

    // words still owed by the block, oldest first
    print_word_t print_q[$];
    print_word_t head;

    // shadow registers and line state
    logic [6:0] tab_w;
    col_t       line_w;
    col_t       col;
    col_t       offs;
    logic       ended;
    int         fails;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // single ending word, then drop until a new line
    task automatic close_line(input reason_t why);
        print_word_t w;
        w.ch     = CH_NUL;
        w.col    = col;
        w.reason = why;
        w.last   = 1'b1;
        print_q.push_back(w);
        ended = 1'b1;
    endtask

    // expand one character into the words it prints
    task automatic format_char(input ch_t c, input logic nl, input col_t so);
        print_word_t w;
        int          t;
        int          len;
        int          i;
        if (nl)
        begin
            col   = '0;
            offs  = so;
            ended = 1'b0;
        end
        if (ended)
            return;
        if (c == CH_NUL)
            close_line(END_TERM);
        else if (c == CH_CR)
            close_line(END_CR);
        else
        begin
            // tab stop counted from column only; width clamped to 1..TAB_LIMIT
            t = int'(tab_w);
            if (t < 1)
                t = 1;
            if (t > TAB_LIMIT)
                t = TAB_LIMIT;
            if (c == CH_TAB)
                len = t - (int'(col) % t);
            else if (c < CH_SPACE)
                len = 2;
            else
                len = 1;
            if (int'(col) + len + int'(offs) > int'(line_w))
                close_line(END_TRUNC);
            else
            begin
                for (i = 0; i < len; i++)
                begin
                    w.col    = col;
                    w.reason = END_NONE;
                    w.last   = (i == len - 1);
                    if (c == CH_TAB)
                        w.ch = CH_SPACE;
                    else if (c < CH_SPACE)
                        w.ch = (i == 0) ? CH_CARET : c + CTRL_BIAS;
                    else
                        w.ch = c;
                    print_q.push_back(w);
                end
                col = col + col_t'(len);
            end
        end
    endtask

    function automatic int field_bad(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // watch all three channels at each edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tab_w  = TAB_WIDTH_RESET;
            line_w = LINE_WIDTH_RESET;
            col    = '0;
            offs   = '0;
            ended  = 1'b0;
            fails  = 0;
            print_q.delete();
        end
        else
        begin
            // result words against the oldest expectation
            if (result.valid && result.ready)
            begin
                if (print_q.size() == 0)
                begin
                    $error("unexpected result word: out_char %0d out_col %0d end_reason %0d",
                           result.out_char, result.out_col, result.end_reason);
                    fails++;
                end
                else
                begin
                    head = print_q.pop_front();
                    fails += field_bad("out_char", int'(head.ch), int'(result.out_char));
                    fails += field_bad("out_col", int'(head.col), int'(result.out_col));
                    fails += field_bad("end_reason", int'(head.reason),
                                       int'(result.end_reason));
                    fails += field_bad("last", int'(head.last), int'(result.last));
                end
            end
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_TAB_WIDTH)
                    tab_w = cfg.data[6:0];
                else if (cfg.index == REG_LINE_WIDTH)
                    line_w = cfg.data;
            end
            // input words
            if (item.valid && item.ready)
                format_char(item.ch, item.new_line, item.start_offset);
        end
        fail_count <= fails;
        pending    <= print_q.size();
    end

endmodule

FILE: dv/tb_tab_expand_caret_line_formatter_core.sv
`timescale 1ns / 1ps

module tb_tab_expand_caret_line_formatter_core;
    import tecl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 120;
    localparam int PHASE_ITEMS = 21;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   cycles;
    int   send_idle;
    int   recv_stall;
    int   line_left;
    col_t cur_line_w;

    tecl_item_if   item_if ();
    tecl_result_if res_if ();
    tecl_cfg_if    cfg_if ();

    tab_expand_caret_line_formatter_core #(
        .TAB_LIMIT(64)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    tecl_print_checker #(
        .TAB_LIMIT(64)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_if),
        .result     (res_if),
        .cfg        (cfg_if),
        .fail_count (fails),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // receiver backpressure
    initial
    begin
        res_if.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        res_if.ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tab_expand_caret_line_formatter_core: mismatch");
            $finish;
        end
    end

    // one input word, with a random gap ahead of it
    task automatic send_char(input ch_t c, input logic nl, input col_t so);
        while ($urandom_range(99) < send_idle)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.ch           <= c;
        item_if.new_line     <= nl;
        item_if.start_offset <= so;
        do
            @(posedge clk);
        while (!item_if.ready);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
    endtask

    // all words out, then room for a dropped character still in flight
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly well-formed lines, some noise
    task automatic send_random_char();
        logic nl;
        col_t so;
        ch_t  c;
        int   r;
        nl = 1'b0;
        so = col_t'($urandom_range(0, 255));
        if (line_left <= 0)
        begin
            nl = 1'b1;
            if ($urandom_range(3) == 0)
                so = col_t'($urandom_range(0, 255));
            else
                so = col_t'($urandom_range(0, int'(cur_line_w) / 2));
            line_left = $urandom_range(1, (cur_line_w < 20) ? 4 : 30);
        end
        else if ($urandom_range(99) < 8)
            nl = 1'b1;
        r = $urandom_range(99);
        if (r < 55)
            c = ch_t'($urandom_range(32, 127));
        else if (r < 70)
            c = CH_TAB;
        else if (r < 82)
            c = ch_t'($urandom_range(1, 31));
        else if (r < 87)
            c = CH_CR;
        else if (r < 91)
            c = CH_NUL;
        else
            c = ch_t'($urandom_range(0, 127));
        if (c == CH_CR || c == CH_NUL)
            line_left = 0;
        else
            line_left--;
        send_char(c, nl, so);
    endtask

    task automatic run_phase(input logic [7:0] tab, input logic [7:0] lw,
                             input int idle_pct, input int stall_pct);
        int n;
        drain();
        write_reg(REG_TAB_WIDTH, tab);
        write_reg(REG_LINE_WIDTH, lw);
        cfg_if.valid <= 1'b0;
        cur_line_w   = lw;
        send_idle    = idle_pct;
        recv_stall   = stall_pct;
        line_left    = 0;
        @(posedge clk);
        for (n = 0; n < PHASE_ITEMS; n++)
            send_random_char();
        item_if.valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        cycles               = 0;
        send_idle            = 0;
        recv_stall           = 0;
        line_left            = 0;
        cur_line_w           = LINE_WIDTH_RESET;
        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.ch           = CH_NUL;
        item_if.new_line     = 1'b0;
        item_if.start_offset = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = REG_TAB_WIDTH;
        cfg_if.data          = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, at reset settings: open line after reset
        send_char(7'd65, 1'b0, 8'd0);
        send_char(7'd127, 1'b0, 8'd0);
        send_char(CH_SPACE, 1'b0, 8'd0);
        send_char(7'd126, 1'b0, 8'd0);
        send_char(CH_TAB, 1'b0, 8'd0);
        send_char(CH_TAB, 1'b0, 8'd0);
        send_char(7'd1, 1'b0, 8'd0);
        send_char(7'd31, 1'b0, 8'd0);
        send_char(7'd27, 1'b0, 8'd0);
        send_char(CH_CR, 1'b0, 8'd0);
        // ended line drops characters
        send_char(7'd120, 1'b0, 8'd0);
        send_char(CH_TAB, 1'b0, 8'd0);
        // offset alone overruns the width
        send_char(7'd97, 1'b1, 8'd255);
        // tab fits, next tab runs past the width
        send_char(CH_TAB, 1'b1, 8'd70);
        send_char(CH_TAB, 1'b0, 8'd0);
        send_char(CH_NUL, 1'b1, 8'd0);
        // exactly at the last column, then one past
        send_char(7'd122, 1'b1, 8'd78);
        send_char(7'd122, 1'b0, 8'd0);
        send_char(7'd2, 1'b1, 8'd77);
        // offset ignored without new_line
        send_char(7'd97, 1'b1, 8'd0);
        send_char(7'd98, 1'b0, 8'd255);
        send_char(7'h55, 1'b1, 8'hAA);
        send_char(CH_CR, 1'b0, 8'h55);
        item_if.valid <= 1'b0;

        // random phases over a spread of settings
        run_phase(8'd4, 8'd40, 0, 0);
        run_phase(8'd1, 8'd255, 61, 0);
        run_phase(8'd64, 8'd255, 0, 61);
        run_phase(8'hFF, 8'd0, 20, 20);
        run_phase(8'd0, 8'd200, 61, 0);
        run_phase(8'd5, 8'd1, 0, 61);
        run_phase(8'd8, 8'd79, 20, 20);
        run_phase(8'd100, 8'd255, 0, 0);
        run_phase(8'd13, 8'd128, 61, 61);

        drain();
        if (fails == 0 && pending == 0)
            $display("tab_expand_caret_line_formatter_core: match");
        else
            $display("tab_expand_caret_line_formatter_core: mismatch");
        $finish;
    end

endmodule

FILE: tab_expand_caret_line_formatter_core.f
hw/rtl/tecl_pkg.sv
hw/rtl/tecl_item_if.sv
hw/rtl/tecl_result_if.sv
hw/rtl/tecl_cfg_if.sv
hw/rtl/tecl_ctrl.sv
hw/rtl/tecl_datapath.sv
hw/rtl/tab_expand_caret_line_formatter_core.sv
dv/tecl_print_checker.sv
dv/tb_tab_expand_caret_line_formatter_core.sv
